@@ rtl/core/csim_pkg.sv @@
package csim_pkg;

   localparam int ELEM_WIDTH = 16;
   localparam int MAX_LEN    = 1024;
   localparam int DOT_W      = 42;
   localparam int NORM_W     = 41;
   localparam int CNT_W      = 11;
   localparam int MAG_W      = 42;
   localparam int PN_W       = 2 * NORM_W;
   localparam int PM_W       = 2 * MAG_W;
   localparam int WIDE_W     = 116;
   localparam int Q_W        = 16;
   localparam int FRAC_W     = 15;
   localparam int STEP_W     = 6;
   localparam int BIT_W      = 4;
   localparam int SIM_W      = 16;

   typedef struct packed {
      logic signed [DOT_W-1:0] dot;
      logic [NORM_W-1:0]       norm_a;
      logic [NORM_W-1:0]       norm_b;
   } sums_type;

   typedef struct packed {
      logic     push;
      logic     pop;
      logic     full;
      logic     empty;
   } queue_ctl_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MULT,
      BK_TRY,
      BK_DECIDE,
      BK_RESULT
   } back_state_type;

endpackage

@@ rtl/core/csim_if.sv @@
interface csim_req_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [csim_pkg::ELEM_WIDTH-1:0]  a_elem;
   logic signed [csim_pkg::ELEM_WIDTH-1:0]  b_elem;
   logic                                    last_elem;

   modport source (output valid, a_elem, b_elem, last_elem, input ready);
   modport sink (input valid, a_elem, b_elem, last_elem, output ready);
endinterface

interface csim_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [csim_pkg::SIM_W-1:0]   similarity;
   logic                                zero_norm;

   modport source (output valid, similarity, zero_norm, input ready);
   modport sink (input valid, similarity, zero_norm, output ready);
endinterface

@@ rtl/core/csim_front.sv @@
module csim_front (
   input  logic                 clock,
   input  logic                 reset,
   csim_req_if.sink             req_ch,
   input  logic                 queue_full,
   output logic                 push,
   output csim_pkg::sums_type   push_data
);

   logic signed [csim_pkg::DOT_W-1:0]  dot_ff, dot_in;
   logic [csim_pkg::NORM_W-1:0]        na_ff, na_in;
   logic [csim_pkg::NORM_W-1:0]        nb_ff, nb_in;
   logic [csim_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [2*csim_pkg::ELEM_WIDTH-1:0] p_ab, p_aa, p_bb;
   logic                               take, room;

   assign req_ch.ready = !queue_full;
   assign take = req_ch.valid && req_ch.ready;
   assign room = (cnt_ff < csim_pkg::CNT_W'(csim_pkg::MAX_LEN));

   assign p_ab = req_ch.a_elem * req_ch.b_elem;
   assign p_aa = req_ch.a_elem * req_ch.a_elem;
   assign p_bb = req_ch.b_elem * req_ch.b_elem;

   // Sums including the current pair, when it still fits.
   always_comb begin
      dot_in = dot_ff;
      na_in  = na_ff;
      nb_in  = nb_ff;
      cnt_in = cnt_ff;
      if (room) begin
         dot_in = dot_ff + csim_pkg::DOT_W'(p_ab);
         na_in  = na_ff + csim_pkg::NORM_W'(unsigned'(p_aa));
         nb_in  = nb_ff + csim_pkg::NORM_W'(unsigned'(p_bb));
         cnt_in = cnt_ff + 1'b1;
      end
   end

   assign push = take && req_ch.last_elem;
   assign push_data = '{dot: dot_in, norm_a: na_in, norm_b: nb_in};

   always_ff @(posedge clock) begin
      if (reset || push) begin
         dot_ff <= '0;
         na_ff  <= '0;
         nb_ff  <= '0;
         cnt_ff <= '0;
      end else if (take) begin
         dot_ff <= dot_in;
         na_ff  <= na_in;
         nb_ff  <= nb_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ rtl/core/csim_queue.sv @@
module csim_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  csim_pkg::queue_ctl_type  ctl_in,
   output csim_pkg::queue_ctl_type  ctl_out,
   input  csim_pkg::sums_type       wr_data,
   output csim_pkg::sums_type       rd_data
);

   csim_pkg::sums_type  slot_ff [2];
   logic                wr_ptr_ff, rd_ptr_ff;
   logic [1:0]          count_ff;
   logic                do_push, do_pop;

   assign ctl_out.push  = do_push;
   assign ctl_out.pop   = do_pop;
   assign ctl_out.full  = (count_ff == 2'd2);
   assign ctl_out.empty = (count_ff == 2'd0);
   assign do_push = ctl_in.push && !ctl_out.full;
   assign do_pop  = ctl_in.pop && !ctl_out.empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(do_push) - 2'(do_pop);
      end
   end

endmodule

@@ rtl/core/csim_back.sv @@
module csim_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 queue_empty,
   output logic                 pop,
   input  csim_pkg::sums_type   pop_data,
   csim_rsp_if.source           rsp_ch
);

   csim_pkg::back_state_type          state_ff, state_in;
   logic [csim_pkg::STEP_W-1:0]       step_ff;
   logic [csim_pkg::BIT_W-1:0]        bit_ff;
   logic [csim_pkg::PN_W-1:0]         mc_a_ff, pp_ff, pp_next;
   logic [csim_pkg::NORM_W-1:0]       mp_b_ff;
   logic [csim_pkg::PM_W-1:0]         mc_m_ff, pm_ff, pm_next;
   logic [csim_pkg::MAG_W-1:0]        mp_m_ff, mag;
   logic [csim_pkg::WIDE_W-1:0]       t_ff, v_ff, w_ff, r_ff, cand_ff, v_acc;
   logic [csim_pkg::Q_W-1:0]          q_ff;
   logic                              neg_ff, zero_ff, fits;
   logic                              out_valid_ff;
   logic signed [csim_pkg::SIM_W-1:0] sim_ff, sim_val;
   logic                              zn_ff, out_free;

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.similarity = sim_ff;
   assign rsp_ch.zero_norm  = zn_ff;

   assign mag = pop_data.dot[csim_pkg::DOT_W-1] ?
                csim_pkg::MAG_W'(-pop_data.dot) : csim_pkg::MAG_W'(pop_data.dot);
   assign pp_next = pp_ff + (mp_b_ff[0] ? mc_a_ff : '0);
   assign pm_next = pm_ff + (mp_m_ff[0] ? mc_m_ff : '0);
   assign fits  = (cand_ff <= r_ff);
   assign v_acc = v_ff + (w_ff << 1);

   always_comb begin
      if (zero_ff) begin
         sim_val = '0;
      end else if (neg_ff) begin
         sim_val = (q_ff > 16'd32768) ? 16'sh8000 : signed'(~q_ff + 1'b1);
      end else begin
         sim_val = (q_ff > 16'd32767) ? 16'sh7FFF : signed'(q_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         csim_pkg::BK_IDLE: begin
            if (!queue_empty) begin
               state_in = (pop_data.norm_a == '0 || pop_data.norm_b == '0) ?
                          csim_pkg::BK_RESULT : csim_pkg::BK_MULT;
            end
         end
         csim_pkg::BK_MULT:   if (step_ff == 6'd1) state_in = csim_pkg::BK_TRY;
         csim_pkg::BK_TRY:    state_in = csim_pkg::BK_DECIDE;
         csim_pkg::BK_DECIDE: begin
            state_in = (bit_ff == '0) ? csim_pkg::BK_RESULT : csim_pkg::BK_TRY;
         end
         csim_pkg::BK_RESULT: if (out_free) state_in = csim_pkg::BK_IDLE;
         default:             state_in = csim_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      pop = (state_ff == csim_pkg::BK_IDLE) && !queue_empty;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= csim_pkg::BK_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         csim_pkg::BK_IDLE: begin
            zero_ff <= (pop_data.norm_a == '0 || pop_data.norm_b == '0);
            neg_ff  <= pop_data.dot[csim_pkg::DOT_W-1];
            mc_a_ff <= csim_pkg::PN_W'(pop_data.norm_a);
            mp_b_ff <= pop_data.norm_b;
            mc_m_ff <= csim_pkg::PM_W'(mag);
            mp_m_ff <= mag;
            pp_ff   <= '0;
            pm_ff   <= '0;
            step_ff <= csim_pkg::STEP_W'(csim_pkg::MAG_W);
         end
         csim_pkg::BK_MULT: begin
            pp_ff   <= pp_next;
            pm_ff   <= pm_next;
            mc_a_ff <= mc_a_ff << 1;
            mp_b_ff <= mp_b_ff >> 1;
            mc_m_ff <= mc_m_ff << 1;
            mp_m_ff <= mp_m_ff >> 1;
            step_ff <= step_ff - 1'b1;
            // Search starts at the top quotient bit.
            t_ff   <= '0;
            v_ff   <= '0;
            w_ff   <= csim_pkg::WIDE_W'(pp_next) << (2 * (csim_pkg::Q_W - 1));
            r_ff   <= csim_pkg::WIDE_W'(pm_next) << (2 * csim_pkg::FRAC_W);
            q_ff   <= '0;
            bit_ff <= csim_pkg::BIT_W'(csim_pkg::Q_W - 1);
         end
         csim_pkg::BK_TRY: begin
            cand_ff <= t_ff + v_ff + w_ff;
         end
         csim_pkg::BK_DECIDE: begin
            if (fits) begin
               t_ff <= cand_ff;
               q_ff <= q_ff | (csim_pkg::Q_W'(1) << bit_ff);
               v_ff <= v_acc >> 1;
            end else begin
               v_ff <= v_ff >> 1;
            end
            w_ff   <= w_ff >> 2;
            bit_ff <= bit_ff - 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == csim_pkg::BK_RESULT && out_free) begin
         sim_ff <= sim_val;
         zn_ff  <= zero_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (state_ff == csim_pkg::BK_RESULT && out_free) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   a_mult_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == csim_pkg::BK_MULT |-> step_ff != '0)
      else $error("multiplier step count ran out");

   a_partial_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == csim_pkg::BK_TRY || state_ff == csim_pkg::BK_DECIDE) |-> t_ff <= r_ff)
      else $error("accepted partial square exceeds target");

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && zn_ff |-> sim_ff == '0)
      else $error("zero norm result is not zero");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff != csim_pkg::BK_IDLE)
      else $error("back end stayed idle after taking sums");

endmodule

@@ rtl/core/cosine_similarity_engine.sv @@
// From the last element transaction to a valid result with an idle back end, the sums
// pass the queue hand-off, 42 shift-add multiply steps, the bit-by-bit quotient search
// and the result register.
// Throughput: one element transaction per cycle while the queue has room; the back end
// takes one vector at a time, paced by the serial multiplier and the quotient search.
// Reset is synchronous and active high; it clears the sums, the queue and result valid.
module cosine_similarity_engine (
   input  logic        clock,
   input  logic        reset,
   csim_req_if.sink    req_ch,
   csim_rsp_if.source  rsp_ch
);

   // The front end forms the three products of each element pair and adds them to
   // the dot and norm sums, up to MAX_LEN pairs. On the last element it hands the
   // finished sums to a two-entry queue and clears itself, so the next vector can
   // stream in while the back end is still working on the previous one.
   csim_pkg::queue_ctl_type  q_ctl_in, q_ctl_out;
   csim_pkg::sums_type       push_data, pop_data;
   logic                     front_push, back_pop;

   csim_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (q_ctl_out.full),
      .push       (front_push),
      .push_data  (push_data)
   );

   always_comb begin
      q_ctl_in       = '0;
      q_ctl_in.push  = front_push;
      q_ctl_in.pop   = back_pop;
   end

   csim_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .ctl_in  (q_ctl_in),
      .ctl_out (q_ctl_out),
      .wr_data (push_data),
      .rd_data (pop_data)
   );

   // The back end squares the dot magnitude and multiplies the norms with a
   // shift-add unit, then finds the largest quotient q with q*q*na*nb no larger
   // than (dot << 15) squared, bit by bit in a try and a decide state, and
   // saturates it; a zero norm gives a zero result. The result sits in an output
   // register so a new set of sums can start while a result transaction waits.
   csim_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (q_ctl_out.empty),
      .pop         (back_pop),
      .pop_data    (pop_data),
      .rsp_ch      (rsp_ch)
   );

endmodule
